@@ rtl/core/dhc_pkg.sv @@
// Package for the datagram header checker: item types, codes, limits and
// the ones'-complement and saturating add helpers. No dependencies.
`default_nettype none

package dhc_pkg;

  localparam int MAX_MSG_BYTES = 1024;
  localparam int MAX_DER_LEN_BYTES = 4;
  localparam int POS_W = 11;
  localparam int SAT_END = MAX_MSG_BYTES + 1;
  localparam int LONG_LIMIT = SAT_END / 256 + 1;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] MAGIC_HI = 8'h23;
  localparam logic [7:0] MAGIC_LO = 8'h7E;
  localparam logic [15:0] CKS_DISABLED = 16'h0000;
  localparam logic [15:0] SUM_GOOD = 16'hFFFF;
  localparam logic [7:0] VERSION_EXT = 8'd1;
  localparam logic [3:0] POFF_EXT = 4'd10;
  localparam logic [3:0] POFF_BASE = 4'd6;
  localparam logic [7:0] DER_INDEFINITE = 8'h80;
  localparam logic [POS_W-1:0] MIN_TOTAL = POS_W'(6);

  // header byte offsets
  localparam logic [3:0] OFF_VERSION = 4'd2;
  localparam logic [3:0] OFF_TYPE = 4'd3;
  localparam logic [3:0] OFF_CKS_HI = 4'd4;
  localparam logic [3:0] OFF_CKS_LO = 4'd5;
  localparam logic [3:0] OFF_TRN_HI = 4'd6;
  localparam logic [3:0] OFF_TRN_LO = 4'd7;
  localparam logic [3:0] OFF_PRT_HI = 4'd8;
  localparam logic [3:0] OFF_PRT_LO = 4'd9;
  localparam logic [3:0] HDR_END = 4'd10;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_MAGIC  = 3'd1,
    ST_CKSUM  = 3'd2,
    ST_LENGTH = 3'd3,
    ST_LONG   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    DER_TAG     = 2'd0,
    DER_LEN     = 2'd1,
    DER_LONGLEN = 2'd2,
    DER_BODY    = 2'd3
  } der_phase_t;

  typedef struct packed {
    logic [7:0] byte_req;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  version;
    logic [7:0]  msg_type;
    logic [15:0] transaction;
    logic [15:0] reply_port;
    logic [3:0]  payload_offset;
    logic [10:0] total_length;
    logic        checksum_checked;
  } verdict_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic [7:0]       byte_req;
    logic             last;
    logic             over;
    logic             magic_err;
    logic [POS_W-1:0] pos;
  } front_item_t;

  typedef struct packed {
    logic not_full;
    logic nonempty;
  } queue_stat_t;

  function automatic logic [15:0] add_ones(input logic [15:0] s, input logic [15:0] w);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, w};
    return t[15:0] + {15'd0, t[16]};
  endfunction

  function automatic logic [POS_W-1:0] sat_end(input logic [POS_W:0] x);
    return (x > (POS_W + 1)'(SAT_END)) ? POS_W'(SAT_END) : x[POS_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/dhc_front.sv @@
// Front end: accepts bytes, tracks the byte position and tags each item
// with position, overflow and magic check. Depends on dhc_pkg.
`default_nettype none

module dhc_front import dhc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_ready,
  input  wire byte_item_t  byte_item,
  input  wire queue_stat_t qstat,
  output logic             push,
  output front_item_t      push_item
);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             over;

  assign byte_ready = qstat.not_full;
  assign push = byte_valid && qstat.not_full;
  assign over = pos >= POS_W'(MAX_MSG_BYTES);

  always_comb begin
    push_item.byte_req = byte_item.byte_req;
    push_item.last = byte_item.last;
    push_item.over = over;
    push_item.pos = pos;
    push_item.magic_err =
      ((pos == POS_W'(0)) && (byte_item.byte_req != MAGIC_HI)) ||
      ((pos == POS_W'(1)) && (byte_item.byte_req != MAGIC_LO));
  end

  always_comb begin
    pos_next = pos;
    if (push) begin
      if (byte_item.last) begin
        pos_next = '0;
      end else if (!over) begin
        pos_next = pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/dhc_queue.sv @@
// Two-entry queue between front and back so either side can stall alone.
// Depends on dhc_pkg.
`default_nettype none

module dhc_queue import dhc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire front_item_t  push_item,
  input  wire logic         pop,
  output front_item_t       head,
  output queue_stat_t       qstat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  front_item_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign qstat.not_full = count != CNT_W'(QUEUE_DEPTH);
  assign qstat.nonempty = count != '0;
  assign do_push = push && qstat.not_full;
  assign do_pop = pop && qstat.nonempty;
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

@@ rtl/core/dhc_back.sv @@
// Back end: checksum, header capture, DER element walk and the verdict
// register. Takes classified items from dhc_queue. Depends on dhc_pkg.
`default_nettype none

module dhc_back import dhc_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire front_item_t  head,
  input  wire queue_stat_t  qstat,
  output logic              pop,
  output logic              verdict_valid,
  input  wire logic         verdict_ready,
  output verdict_t          verdict
);

  logic [15:0]      ones_sum, ones_sum_next;
  logic [7:0]       held, held_next;
  logic [7:0]       version, version_next;
  logic [7:0]       msg_type, msg_type_next;
  logic [15:0]      cks, cks_next;
  logic [15:0]      trn, trn_next;
  logic [15:0]      prt, prt_next;
  der_phase_t       der_phase, der_phase_next;
  logic [2:0]       der_left, der_left_next;
  logic [POS_W-1:0] der_end, der_end_next;
  logic             err_magic, err_magic_next;
  logic             err_long, err_long_next;
  logic             err_der, err_der_next;

  logic             take;
  logic             load;
  logic             der_en;
  logic [3:0]       poff;
  logic [7:0]       b;
  logic [POS_W-1:0] acc;
  logic             len_bad;
  logic [POS_W-1:0] total;
  logic [15:0]      fsum;
  logic             checked;
  logic [2:0]       status;
  logic             ext;

  assign take = qstat.nonempty && (!head.last || !verdict_valid || verdict_ready);
  assign pop = take;
  assign load = take && head.last;
  assign b = head.byte_req;
  assign poff = (version == VERSION_EXT) ? POFF_EXT : POFF_BASE;
  assign der_en = take && !head.over && (head.pos >= POS_W'(poff));
  assign len_bad = (b == DER_INDEFINITE) || (b[6:0] > 7'(MAX_DER_LEN_BYTES));

  // per-byte header, checksum and error flags
  always_comb begin
    ones_sum_next = ones_sum;
    held_next = held;
    version_next = version;
    msg_type_next = msg_type;
    cks_next = cks;
    trn_next = trn;
    prt_next = prt;
    err_magic_next = err_magic;
    err_long_next = err_long;
    if (head.over) begin
      err_long_next = 1'b1;
    end else begin
      if (head.magic_err) begin
        err_magic_next = 1'b1;
      end
      if (head.pos < POS_W'(HDR_END)) begin
        case (head.pos[3:0])
          OFF_VERSION: version_next = b;
          OFF_TYPE:    msg_type_next = b;
          OFF_CKS_HI:  cks_next[15:8] = b;
          OFF_CKS_LO:  cks_next[7:0] = b;
          OFF_TRN_HI:  trn_next[15:8] = b;
          OFF_TRN_LO:  trn_next[7:0] = b;
          OFF_PRT_HI:  prt_next[15:8] = b;
          OFF_PRT_LO:  prt_next[7:0] = b;
          default: ;
        endcase
      end
      if (!head.pos[0]) begin
        held_next = b;
      end else begin
        ones_sum_next = add_ones(ones_sum, {held, b});
      end
    end
  end

  // DER phase, next state
  always_comb begin
    der_phase_next = der_phase;
    if (der_en) begin
      case (der_phase)
        DER_TAG: der_phase_next = DER_LEN;
        DER_LEN: begin
          if (!b[7] || len_bad) begin
            der_phase_next = DER_BODY;
          end else begin
            der_phase_next = DER_LONGLEN;
          end
        end
        DER_LONGLEN: begin
          if (der_left == 3'd1) begin
            der_phase_next = DER_BODY;
          end
        end
        DER_BODY: der_phase_next = DER_BODY;
        default: der_phase_next = DER_TAG;
      endcase
    end
  end

  // DER length bookkeeping
  always_comb begin
    der_left_next = der_left;
    der_end_next = der_end;
    err_der_next = err_der;
    acc = (der_end >= POS_W'(LONG_LIMIT)) ? POS_W'(SAT_END)
                                          : sat_end({1'b0, der_end[2:0], b});
    if (der_en) begin
      case (der_phase)
        DER_LEN: begin
          if (!b[7]) begin
            der_end_next = sat_end((POS_W + 1)'(head.pos) + (POS_W + 1)'(1)
                                   + (POS_W + 1)'(b));
          end else if (len_bad) begin
            err_der_next = 1'b1;
            der_end_next = POS_W'(SAT_END);
          end else begin
            der_left_next = b[2:0];
            der_end_next = '0;
          end
        end
        DER_LONGLEN: begin
          der_left_next = der_left - 3'd1;
          if (der_left == 3'd1) begin
            der_end_next = sat_end((POS_W + 1)'(head.pos) + (POS_W + 1)'(1)
                                   + (POS_W + 1)'(acc));
          end else begin
            der_end_next = acc;
          end
        end
        default: ;
      endcase
    end
  end

  // verdict from the updated state
  always_comb begin
    total = head.over ? head.pos : head.pos + POS_W'(1);
    fsum = total[0] ? add_ones(ones_sum_next, {held_next, 8'h00}) : ones_sum_next;
    checked = 1'b0;
    if (err_long_next) begin
      status = ST_LONG;
    end else if ((total <= MIN_TOTAL) || err_magic_next) begin
      status = ST_MAGIC;
    end else begin
      checked = cks_next != CKS_DISABLED;
      if (checked && (fsum != SUM_GOOD)) begin
        status = ST_CKSUM;
      end else if (err_der_next || (der_phase_next != DER_BODY)
                   || (der_end_next != total)) begin
        status = ST_LENGTH;
      end else begin
        status = ST_OK;
      end
    end
    ext = version_next == VERSION_EXT;
  end

  always_ff @(posedge clk) begin
    if (rst || load) begin
      ones_sum <= '0;
      held <= '0;
      version <= '0;
      msg_type <= '0;
      cks <= '0;
      trn <= '0;
      prt <= '0;
      der_phase <= DER_TAG;
      der_left <= '0;
      der_end <= '0;
      err_magic <= 1'b0;
      err_long <= 1'b0;
      err_der <= 1'b0;
    end else if (take) begin
      ones_sum <= ones_sum_next;
      held <= held_next;
      version <= version_next;
      msg_type <= msg_type_next;
      cks <= cks_next;
      trn <= trn_next;
      prt <= prt_next;
      der_phase <= der_phase_next;
      der_left <= der_left_next;
      der_end <= der_end_next;
      err_magic <= err_magic_next;
      err_long <= err_long_next;
      err_der <= err_der_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (load) begin
      verdict_valid <= 1'b1;
    end else if (verdict_ready) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      verdict.status <= status;
      verdict.version <= version_next;
      verdict.msg_type <= msg_type_next;
      verdict.transaction <= ext ? trn_next : 16'd0;
      verdict.reply_port <= ext ? prt_next : 16'd0;
      verdict.payload_offset <= ext ? POFF_EXT : POFF_BASE;
      verdict.total_length <= total;
      verdict.checksum_checked <= checked;
    end
  end

  a_left_only_longlen: assert property (@(posedge clk) disable iff (rst)
    (der_phase != DER_LONGLEN) |-> (der_left == 3'd0))
    else $error("length byte count outside long-form phase");

  a_end_saturates: assert property (@(posedge clk) disable iff (rst)
    der_end <= POS_W'(SAT_END))
    else $error("element end beyond saturation");

  a_clear_after_verdict: assert property (@(posedge clk) disable iff (rst)
    load |=> (der_phase == DER_TAG) && (ones_sum == 16'd0) && !err_magic
             && !err_long && !err_der)
    else $error("state not cleared after verdict");

endmodule

`default_nettype wire

@@ rtl/core/datagram_header_checker_top.sv @@
// Datagram header checker: one byte item per cycle in, one verdict item per
// datagram out at its last byte. verdict_valid is registered and rises in the
// cycle after the back end pops the last byte, after any items queued ahead.
// Throughput: one byte per cycle; only a verdict waiting on verdict_ready stalls.
// Reset (rst, synchronous) empties the queue and clears all datagram state.
// Depends on dhc_pkg, dhc_front, dhc_queue, dhc_back.
`default_nettype none

module datagram_header_checker_top import dhc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_ready,
  input  wire byte_item_t  byte_item,
  output logic             verdict_valid,
  input  wire logic        verdict_ready,
  output verdict_t         verdict
);

  queue_stat_t qstat;
  logic        push;
  logic        pop;
  front_item_t push_item;
  front_item_t head;

  dhc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .qstat      (qstat),
    .push       (push),
    .push_item  (push_item)
  );

  dhc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  dhc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .qstat         (qstat),
    .pop           (pop),
    .verdict_valid (verdict_valid),
    .verdict_ready (verdict_ready),
    .verdict       (verdict)
  );

endmodule

`default_nettype wire
